### hw/rtl/rtcm3_frame_sync_crc24q_macros.svh
// assertion macros for the rtcm3 frame sync block
`ifndef RTCM3_FRAME_SYNC_CRC24Q_MACROS_SVH
`define RTCM3_FRAME_SYNC_CRC24Q_MACROS_SVH
`ifndef SYNTHESIS
`define RFS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfs check failed");
`define RFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfs check failed");
`else
`define RFS_ASSERT_SAME(lbl, ante, cons)
`define RFS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/rfs_pkg.sv
package rfs_pkg;

    localparam logic [7:0]  SYNC_BYTE = 8'hD3;
    localparam logic [7:0]  RSV_MASK  = 8'hFC;
    localparam logic [23:0] POLY24    = 24'h864CFB;
    localparam logic [10:0] HDR_CHK   = 11'd6;
    localparam logic [10:0] HDR_BYTES = 11'd3;
    localparam int          TDATA_W   = 144;

    typedef struct packed {
        logic        ovf;
        logic [31:0] discards;
        logic [31:0] crc_fails;
        logic [31:0] frames;
        logic [10:0] length;
        logic [31:0] start;
    } res_t;

    // one byte of crc24q, msb first
    function automatic logic [23:0] crc_step(input logic [23:0] crc, input logic [7:0] b);
        logic [23:0] c;
        logic        top;
        c = crc ^ {b, 16'h0000};
        for (int k = 0; k < 8; k++)
        begin
            top = c[23];
            c = {c[22:0], 1'b0};
            if (top)
                c = c ^ POLY24;
        end
        return c;
    endfunction

endpackage

### hw/rtl/rtcm3_frame_sync_crc24q.sv
// rtcm3 frame synchronizer with crc24q check
// input channel s_*: one transaction is one stream byte (s_tuser = 0) or a
//   flush command (s_tuser = 1); s_tdata carries the byte
// output channel m_*: each transaction is one result; m_tuser = 1 marks an
//   accepted frame (offset and length), m_tuser = 0 with m_tlast = 1 is the
//   status result that closes the run of every input transaction
// the bytes sit in a single-port-write, registered-read store; a sequencer
//   rescans them from the oldest byte after each appended byte
// steps: taking the input transaction, then for every stored byte the scan
//   walks past an address and a compare; a header reads sync, reserved bits
//   and length, a frame check runs the crc over header and payload, reads
//   the three crc bytes and compares, an accepted frame then loads its
//   result, the status load closes; a new input waits for the status load
// the store read port (one byte per read, registered read) sets the pace
// reset clears head, fill count, stream offset and the frame, crc failure and
//   discard counters; the store contents need no reset since only written entries are read
// a stalled receiver holds the output register; the scan waits at the next
//   result, a new input is taken while the status result still waits
module rtcm3_frame_sync_crc24q
    import rfs_pkg::*;
#(
    parameter int STORE_DEPTH         = 2048,
    parameter int MAX_FRAMES_PER_BYTE = 63
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // data_byte[7:0]
    input  logic               s_tuser,   // cmd
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // frame_start, frame_length, frames_total,
                                          // crc_fail_total, discard_total,
                                          // cascade_overflow, zero pad
    output logic               m_tuser,   // is_frame
    output logic               m_tlast    // last
);

    `include "rtcm3_frame_sync_crc24q_macros.svh"

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int NW = $clog2(MAX_FRAMES_PER_BYTE + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CHK    = 4'd1;
    localparam logic [3:0] ST_B0     = 4'd2;
    localparam logic [3:0] ST_B1     = 4'd3;
    localparam logic [3:0] ST_B2     = 4'd4;
    localparam logic [3:0] ST_CRC    = 4'd5;
    localparam logic [3:0] ST_RX0    = 4'd6;
    localparam logic [3:0] ST_RX1    = 4'd7;
    localparam logic [3:0] ST_RX2    = 4'd8;
    localparam logic [3:0] ST_CMP    = 4'd9;
    localparam logic [3:0] ST_EMIT   = 4'd10;
    localparam logic [3:0] ST_STATUS = 4'd11;

    // head plus offset, wrapped once around the store
    function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] h, input logic [CW-1:0] p);
        logic [SW-1:0] s;
        s = SW'(h) + SW'(p);
        if (s >= SW'(STORE_DEPTH))
            s = s - SW'(STORE_DEPTH);
        return s[AW-1:0];
    endfunction

    logic [7:0]    store_mem [STORE_DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;

    logic [3:0]    state_reg,   state_next;
    logic [AW-1:0] head_reg,    head_next;
    logic [CW-1:0] pending_reg, pending_next;
    logic [31:0]   offset_reg,  offset_next;
    logic [31:0]   frames_reg,  frames_next;
    logic [31:0]   crcf_reg,    crcf_next;
    logic [31:0]   disc_reg,    disc_next;
    logic [CW-1:0] cursor_reg,  cursor_next;
    logic [CW-1:0] pos_reg,     pos_next;
    logic [9:0]    plen_reg,    plen_next;
    logic [10:0]   cnt_reg,     cnt_next;
    logic [23:0]   crc_reg,     crc_next;
    logic [23:0]   rx_reg,      rx_next;
    logic [NW-1:0] nfr_reg,     nfr_next;
    logic          ovf_reg,     ovf_next;
    logic          ov_reg,      ov_next;     // output valid
    res_t          res_reg,     res_next;
    logic          isf_reg,     isf_next;
    logic          lst_reg,     lst_next;

    logic          slot_free;
    logic [10:0]   fsize;
    logic [CW-1:0] remain;
    logic [AW-1:0] head_drop;
    logic [CW-1:0] pend_drop;

    assign slot_free = !ov_reg || m_tready;
    assign fsize     = HDR_CHK + 11'(plen_reg);
    assign remain    = pending_reg - cursor_reg;
    assign s_tready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        pending_next = pending_reg;
        offset_next  = offset_reg;
        frames_next  = frames_reg;
        crcf_next    = crcf_reg;
        disc_next    = disc_reg;
        cursor_next  = cursor_reg;
        pos_next     = pos_reg;
        plen_next    = plen_reg;
        cnt_next     = cnt_reg;
        crc_next     = crc_reg;
        rx_next      = rx_reg;
        nfr_next     = nfr_reg;
        ovf_next     = ovf_reg;
        ov_next      = ov_reg && !m_tready;
        res_next     = res_reg;
        isf_next     = isf_reg;
        lst_next     = lst_reg;
        wr_en        = 1'b0;
        head_drop    = head_reg;
        pend_drop    = pending_reg;
        wr_addr      = wrap_addr(head_reg, pending_reg);
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ovf_next = 1'b0;
                    nfr_next = '0;
                    if (s_tuser)
                    begin
                        // flush: status commits the whole fill as consumed
                        disc_next   = disc_reg + 32'(pending_reg);
                        cursor_next = pending_reg;
                        state_next  = ST_STATUS;
                    end
                    else
                    begin
                        if (pending_reg >= CW'(STORE_DEPTH))
                        begin
                            head_drop   = wrap_addr(head_reg, CW'(1));
                            pend_drop   = pending_reg - CW'(1);
                            disc_next   = disc_reg + 32'd1;
                            offset_next = offset_reg + 32'd1;
                        end
                        head_next    = head_drop;
                        wr_addr      = wrap_addr(head_drop, pend_drop);
                        wr_en        = 1'b1;
                        pending_next = pend_drop + CW'(1);
                        cursor_next  = '0;
                        state_next   = ST_CHK;
                    end
                end
            end
            ST_CHK:
            begin
                if (cursor_reg >= pending_reg)
                    state_next = ST_STATUS;
                else
                begin
                    pos_next   = cursor_reg;
                    state_next = ST_B0;
                end
            end
            ST_B0:
            begin
                if (rd_data_reg != SYNC_BYTE)
                begin
                    cursor_next = cursor_reg + CW'(1);
                    disc_next   = disc_reg + 32'd1;
                    state_next  = ST_CHK;
                end
                else if (remain < CW'(HDR_BYTES))
                    state_next = ST_STATUS;
                else
                begin
                    pos_next   = cursor_reg + CW'(1);
                    state_next = ST_B1;
                end
            end
            ST_B1:
            begin
                if ((rd_data_reg & RSV_MASK) != 8'h00)
                begin
                    cursor_next = cursor_reg + CW'(1);
                    disc_next   = disc_reg + 32'd1;
                    state_next  = ST_CHK;
                end
                else
                begin
                    plen_next[9:8] = rd_data_reg[1:0];
                    pos_next       = cursor_reg + CW'(2);
                    state_next     = ST_B2;
                end
            end
            ST_B2:
            begin
                plen_next[7:0] = rd_data_reg;
                if (remain < CW'(HDR_CHK + 11'(plen_reg[9:8]) * 11'd256 + 11'(rd_data_reg)))
                    state_next = ST_STATUS;
                else
                begin
                    pos_next   = cursor_reg;
                    crc_next   = '0;
                    cnt_next   = HDR_BYTES + 11'({plen_reg[9:8], rd_data_reg});
                    state_next = ST_CRC;
                end
            end
            ST_CRC:
            begin
                crc_next = crc_step(crc_reg, rd_data_reg);
                pos_next = pos_reg + CW'(1);
                cnt_next = cnt_reg - 11'd1;
                if (cnt_reg == 11'd1)
                    state_next = ST_RX0;
            end
            ST_RX0:
            begin
                rx_next[23:16] = rd_data_reg;
                pos_next       = pos_reg + CW'(1);
                state_next     = ST_RX1;
            end
            ST_RX1:
            begin
                rx_next[15:8] = rd_data_reg;
                pos_next      = pos_reg + CW'(1);
                state_next    = ST_RX2;
            end
            ST_RX2:
            begin
                rx_next[7:0] = rd_data_reg;
                state_next   = ST_CMP;
            end
            ST_CMP:
            begin
                if (crc_reg != rx_reg)
                begin
                    crcf_next   = crcf_reg + 32'd1;
                    cursor_next = cursor_reg + CW'(1);
                    disc_next   = disc_reg + 32'd1;
                    state_next  = ST_CHK;
                end
                else
                begin
                    frames_next = frames_reg + 32'd1;
                    if (32'(nfr_reg) < 32'(MAX_FRAMES_PER_BYTE))
                        state_next = ST_EMIT;
                    else
                    begin
                        // cascade overflow: frame consumed, no result
                        ovf_next    = 1'b1;
                        cursor_next = cursor_reg + CW'(fsize);
                        state_next  = ST_CHK;
                    end
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next            = 1'b1;
                    isf_next           = 1'b1;
                    lst_next           = 1'b0;
                    res_next.start     = offset_reg + 32'(cursor_reg);
                    res_next.length    = fsize;
                    res_next.frames    = frames_reg;
                    res_next.crc_fails = crcf_reg;
                    res_next.discards  = disc_reg;
                    res_next.ovf       = 1'b0;
                    nfr_next           = nfr_reg + NW'(1);
                    cursor_next        = cursor_reg + CW'(fsize);
                    state_next         = ST_CHK;
                end
            end
            ST_STATUS:
            begin
                if (slot_free)
                begin
                    ov_next            = 1'b1;
                    isf_next           = 1'b0;
                    lst_next           = 1'b1;
                    res_next.start     = offset_reg + 32'(cursor_reg);
                    res_next.length    = '0;
                    res_next.frames    = frames_reg;
                    res_next.crc_fails = crcf_reg;
                    res_next.discards  = disc_reg;
                    res_next.ovf       = ovf_reg;
                    head_next          = wrap_addr(head_reg, cursor_reg);
                    pending_next       = pending_reg - cursor_reg;
                    offset_next        = offset_reg + 32'(cursor_reg);
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        rd_addr = wrap_addr(head_next, pos_next);
    end

    // byte store: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= s_tdata;
        rd_data_reg <= store_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            pending_reg <= '0;
            offset_reg  <= '0;
            frames_reg  <= '0;
            crcf_reg    <= '0;
            disc_reg    <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            pending_reg <= pending_next;
            offset_reg  <= offset_next;
            frames_reg  <= frames_next;
            crcf_reg    <= crcf_next;
            disc_reg    <= disc_next;
            ov_reg      <= ov_next;
        end
    end

    // scan scratch and output payload
    always_ff @(posedge clk)
    begin
        cursor_reg <= cursor_next;
        pos_reg    <= pos_next;
        plen_reg   <= plen_next;
        cnt_reg    <= cnt_next;
        crc_reg    <= crc_next;
        rx_reg     <= rx_next;
        nfr_reg    <= nfr_next;
        ovf_reg    <= ovf_next;
        res_reg    <= res_next;
        isf_reg    <= isf_next;
        lst_reg    <= lst_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {4'b0000, res_reg};
    assign m_tuser  = isf_reg;
    assign m_tlast  = lst_reg;

    // a data byte always starts a rescan from the oldest byte
    `RFS_ASSERT_NEXT(a_byte_scans, s_tvalid && s_tready && !s_tuser, state_reg == ST_CHK)
    // frame results never exceed the per-byte limit
    `RFS_ASSERT_SAME(a_emit_limit, state_reg == ST_EMIT, 32'(nfr_reg) < 32'(MAX_FRAMES_PER_BYTE))
    // the status load always leaves a closing result in the output register
    `RFS_ASSERT_NEXT(a_status_out, state_reg == ST_STATUS && slot_free,
                     m_tvalid && m_tlast && !m_tuser)
    // the fill never exceeds the store
    `RFS_ASSERT_SAME(a_fill_bound, state_reg != ST_IDLE, pending_reg <= CW'(STORE_DEPTH))

endmodule
